@@ hdl/lkvc_pkg.sv @@
// Shared constants and beat types for the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic              CMD_GET   = 1'b0;
  localparam logic              CMD_PUT   = 1'b1;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
  } rsp_t;

endpackage
`default_nettype wire

@@ hdl/lkvc_in_stage.sv @@
// Input register: holds one request beat for the lookup-and-update pass.
`default_nettype none
module lkvc_in_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_cmd,
  input  wire logic signed [lkvc_pkg::DATA_W-1:0] in_key,
  input  wire logic signed [lkvc_pkg::DATA_W-1:0] in_write_value,
  input  wire logic                             take,
  output logic                                  req_valid,
  output lkvc_pkg::req_t                        req
);

  logic           valid_r, valid_nxt;
  lkvc_pkg::req_t req_r, req_nxt;
  logic           load;

  assign load      = in_valid && (!valid_r || take);
  assign in_stall  = valid_r && !take;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    valid_nxt = valid_r;
    req_nxt   = req_r;
    if (load) begin
      valid_nxt           = 1'b1;
      req_nxt.cmd         = in_cmd;
      req_nxt.key         = in_key;
      req_nxt.write_value = in_write_value;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/lkvc_store.sv @@
// Entry store: parallel key match, age-ordered LRU update and capacity register.
`default_nettype none
module lkvc_store (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lkvc_pkg::CAP_W-1:0]     cfg_capacity,
  input  wire logic                           fire,
  input  wire lkvc_pkg::req_t                 req,
  output lkvc_pkg::rsp_t                      rsp,
  output logic [lkvc_pkg::CNT_W-1:0]          count_o
);

  localparam int N = lkvc_pkg::ENTRIES;

  logic [lkvc_pkg::DATA_W-1:0] key_r [N];
  logic [lkvc_pkg::DATA_W-1:0] key_nxt [N];
  logic [lkvc_pkg::DATA_W-1:0] val_r [N];
  logic [lkvc_pkg::DATA_W-1:0] val_nxt [N];
  logic [lkvc_pkg::AGE_W-1:0]  age_r [N];
  logic [lkvc_pkg::AGE_W-1:0]  age_nxt [N];
  logic [N-1:0]                valid_r, valid_nxt;
  logic [lkvc_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [lkvc_pkg::CAP_W-1:0]  cap_r;

  logic [N-1:0]                match;
  logic                        hit;
  logic [lkvc_pkg::DATA_W-1:0] hit_val;
  logic [lkvc_pkg::AGE_W-1:0]  hit_age;
  logic [lkvc_pkg::CNT_W-1:0]  cnt_m1;
  logic [lkvc_pkg::AGE_W-1:0]  last_age;
  logic [lkvc_pkg::CMP_W-1:0]  cap_eff;
  logic                        overflow;
  logic                        ins_path;
  logic                        ev;
  logic                        do_evict;
  logic                        stores;
  logic [N-1:0]                evict_vec;
  logic [N-1:0]                valid_after;
  logic [N-1:0]                free_vec;
  logic [N-1:0]                slot_vec;
  logic                        do_insert;

  assign count_o = count_r;

  always_comb begin
    match   = '0;
    hit_val = '0;
    hit_age = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req.key);
      if (match[i]) begin
        hit_val = hit_val | val_r[i];
        hit_age = hit_age | age_r[i];
      end
    end
    hit = |match;

    cnt_m1   = count_r - lkvc_pkg::CNT_W'(1);
    last_age = cnt_m1[lkvc_pkg::AGE_W-1:0];
    cap_eff  = (lkvc_pkg::CMP_W'(cap_r) > lkvc_pkg::CMP_W'(N)) ?
               lkvc_pkg::CMP_W'(N) : lkvc_pkg::CMP_W'(cap_r);
    overflow = (lkvc_pkg::CMP_W'(count_r) + lkvc_pkg::CMP_W'(1)) > cap_eff;

    ins_path = (req.cmd == lkvc_pkg::CMD_PUT) && !hit;
    ev       = ins_path && overflow;
    do_evict = ev && (count_r != '0);
    // empty store with zero capacity: the new entry is dropped at once
    stores   = ins_path && !(ev && (count_r == '0));

    for (int i = 0; i < N; i++) begin
      evict_vec[i] = do_evict && valid_r[i] && (age_r[i] == last_age);
    end
    valid_after = valid_r & ~evict_vec;
    free_vec    = ~valid_after;
    slot_vec    = free_vec & (~free_vec + N'(1));
    do_insert   = stores && (|free_vec);

    key_nxt   = key_r;
    val_nxt   = val_r;
    age_nxt   = age_r;
    valid_nxt = valid_r;
    count_nxt = count_r;

    if (fire) begin
      if (hit) begin
        for (int i = 0; i < N; i++) begin
          if (valid_r[i] && (age_r[i] < hit_age)) begin
            age_nxt[i] = age_r[i] + lkvc_pkg::AGE_W'(1);
          end
          if (match[i]) begin
            age_nxt[i] = '0;
            if (req.cmd == lkvc_pkg::CMD_PUT) begin
              val_nxt[i] = req.write_value;
            end
          end
        end
      end else if (stores) begin
        for (int i = 0; i < N; i++) begin
          if (valid_after[i]) begin
            age_nxt[i] = age_r[i] + lkvc_pkg::AGE_W'(1);
          end
          if (evict_vec[i]) begin
            age_nxt[i] = '0;
          end
          if (do_insert && slot_vec[i]) begin
            key_nxt[i] = req.key;
            val_nxt[i] = req.write_value;
            age_nxt[i] = '0;
          end
        end
        valid_nxt = valid_after | (do_insert ? slot_vec : '0);
        count_nxt = count_r - lkvc_pkg::CNT_W'(do_evict)
                            + lkvc_pkg::CNT_W'(do_insert);
      end
    end

    rsp.hit     = hit;
    rsp.evicted = ev;
    if (req.cmd == lkvc_pkg::CMD_GET) begin
      rsp.read_value = hit ? hit_val : lkvc_pkg::MISS_VALUE;
    end else begin
      rsp.read_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      cap_r   <= lkvc_pkg::CAP_RESET;
      for (int i = 0; i < N; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      age_r   <= age_nxt;
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/lkvc_out_stage.sv @@
// Result register: holds one response beat until the consumer takes it.
`default_nettype none
module lkvc_out_stage (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               load,
  input  wire lkvc_pkg::rsp_t                     rsp,
  output logic                                    space,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic signed [lkvc_pkg::DATA_W-1:0]      out_read_value,
  output logic                                    out_evicted
);

  logic           valid_r, valid_nxt;
  lkvc_pkg::rsp_t rsp_r, rsp_nxt;

  assign space          = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_hit        = rsp_r.hit;
  assign out_read_value = rsp_r.read_value;
  assign out_evicted    = rsp_r.evicted;

  always_comb begin
    valid_nxt = valid_r;
    rsp_nxt   = rsp_r;
    if (load) begin
      valid_nxt = 1'b1;
      rsp_nxt   = rsp;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache.
// Fully associative 16-entry key-value store with least-recently-used
// replacement; each input beat is a get (cmd 0) or a put (cmd 1) and gives
// exactly one result beat. One beat is taken every cycle unless out_stall
// holds a full result register: the key match over all entries and the
// age update run combinationally between the input register and the
// result register, so out_valid rises once a beat has passed both. out_stall
// reaches in_stall combinationally, with no register between. The store is
// empty after reset; cfg_ready is always high and capacity should only be
// written while no beat is in flight.
`default_nettype none
module lru_key_value_cache (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_cmd,
  input  wire logic signed [lkvc_pkg::DATA_W-1:0] in_key,
  input  wire logic signed [lkvc_pkg::DATA_W-1:0] in_write_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic signed [lkvc_pkg::DATA_W-1:0]      out_read_value,
  output logic                                    out_evicted,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lkvc_pkg::CAP_W-1:0]         cfg_capacity
);

  logic                       req_valid;
  lkvc_pkg::req_t             req;
  lkvc_pkg::rsp_t             rsp;
  logic                       space;
  logic                       take;
  logic [lkvc_pkg::CNT_W-1:0] count;

  assign cfg_ready = 1'b1;
  assign take      = req_valid && space;

  lkvc_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .take           (take),
    .req_valid      (req_valid),
    .req            (req)
  );

  lkvc_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_capacity),
    .fire         (take),
    .req          (req),
    .rsp          (rsp),
    .count_o      (count)
  );

  lkvc_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (take),
    .rsp            (rsp),
    .space          (space),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES))
    else $error("entry count above store size");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (take && rsp.evicted) |-> (!rsp.hit && req.cmd == lkvc_pkg::CMD_PUT))
    else $error("eviction on a hit or a get");

  a_get_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (take && req.cmd == lkvc_pkg::CMD_GET && !rsp.hit) |=>
      (out_valid && out_read_value == lkvc_pkg::MISS_VALUE))
    else $error("get miss did not return all ones");

  a_count_steady_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (take && rsp.hit) |=> $stable(count))
    else $error("entry count changed on a hit");

endmodule
`default_nettype wire
